### rtl/core/rational_add_sub_reduce_macros.svh
// Assertion macros used by the checker file.
`ifndef RATIONAL_ADD_SUB_REDUCE_MACROS_SVH
`define RATIONAL_ADD_SUB_REDUCE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RASR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define RASR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/core/rasr_pkg.sv
// Package with widths, command codes and shared types of the rational block.
package rasr_pkg;
  localparam int OpW  = 16;
  localparam int ProdW = 2 * OpW;
  localparam int WideW = ProdW + 2;
  localparam int NumW = 33;
  localparam int DenW = 32;
  localparam int CntW = $clog2(WideW + 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_NEG = 2'd2,
    CMD_EQ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic comb;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } rasr_cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } rasr_sts_t;
endpackage

### rtl/core/rasr_if.sv
// Valid/ready channel interfaces for input and result words.
interface rasr_in_if;
  import rasr_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic signed [OpW-1:0] a_num;
  logic [OpW-1:0] a_den;
  logic signed [OpW-1:0] b_num;
  logic [OpW-1:0] b_den;
  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rasr_out_if;
  import rasr_pkg::*;
  logic valid;
  logic ready;
  logic signed [NumW-1:0] res_num;
  logic [DenW-1:0] res_den;
  logic equal;
  logic error;
  modport source (output valid, res_num, res_den, equal, error, input ready);
  modport sink (input valid, res_num, res_den, equal, error, output ready);
endinterface

### rtl/core/rasr_datapath.sv
// Datapath: cross products, binary GCD and restoring division by the GCD.
module rasr_datapath (
  input  logic clk_i,
  input  rasr_pkg::rasr_cmd_t cmd_i,
  input  logic [1:0] op_i,
  input  logic [rasr_pkg::OpW-1:0] a_num_i,
  input  logic [rasr_pkg::OpW-1:0] a_den_i,
  input  logic [rasr_pkg::OpW-1:0] b_num_i,
  input  logic [rasr_pkg::OpW-1:0] b_den_i,
  output rasr_pkg::rasr_sts_t sts_o,
  output logic [rasr_pkg::NumW-1:0] res_num_o,
  output logic [rasr_pkg::DenW-1:0] res_den_o,
  output logic equal_o,
  output logic error_o
);
  import rasr_pkg::*;

  logic [1:0] op_q;
  logic [OpW-1:0] an_q, ad_q, bn_q, bd_q;
  logic [WideW-1:0] p1_q, p2_q, den_q;
  logic [WideW-1:0] mag_q, x_q, y_q, q_q, r_q, dvd_q;
  logic neg_q, second_q, special_q;
  logic [CntW-1:0] sh_q, cnt_q;
  logic [NumW-1:0] res_num_q;
  logic [DenW-1:0] res_den_q;
  logic equal_q, error_q;
  logic equal_out_q, error_out_q;

  logic [WideW-1:0] an_x, bn_x, sum, mag_d, rt, rsub, ys;
  logic errz;

  assign an_x = WideW'($signed(an_q));
  assign bn_x = WideW'($signed(bn_q));
  assign errz = (ad_q == '0) || (op_q != CMD_NEG && bd_q == '0);

  always_comb begin
    case (op_q)
      CMD_ADD: sum = p1_q + p2_q;
      CMD_SUB: sum = p1_q - p2_q;
      default: sum = '0 - an_x;
    endcase
  end

  assign mag_d = sum[WideW-1] ? '0 - sum : sum;

  // One binary GCD step: a common factor of two is counted and removed, a lone
  // factor of two leaves x or y, or when both are odd y takes the difference.
  assign ys = (x_q > y_q) ? x_q - y_q : y_q - x_q;

  assign rt = {r_q[WideW-2:0], dvd_q[WideW-1]};
  assign rsub = rt - x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    if (cmd_i.mul) begin
      // Each product is a single multiply of a signed 16-bit numerator by an unsigned 16-bit denominator.
      p1_q <= WideW'($signed(an_x) * $signed({2'b0, bd_q}));
      p2_q <= WideW'($signed(bn_x) * $signed({2'b0, ad_q}));
      den_q <= (op_q == CMD_NEG) ? WideW'(ad_q) : WideW'(ProdW'(ad_q) * ProdW'(bd_q));
      special_q <= errz;
      error_q <= errz;
      equal_q <= 1'b0;
    end
    if (cmd_i.comb) begin
      neg_q <= sum[WideW-1];
      mag_q <= mag_d;
      if (!error_q && op_q == CMD_EQ) begin
        equal_q <= (p1_q == p2_q);
        special_q <= 1'b1;
      end else if (!error_q && sum == '0) begin
        special_q <= 1'b1;
      end
    end
    if (cmd_i.gcd_init) begin
      x_q <= mag_d;
      y_q <= den_q;
      sh_q <= '0;
    end
    if (cmd_i.gcd_step) begin
      if (x_q[0] == 1'b0 && y_q[0] == 1'b0) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        sh_q <= sh_q + 1'b1;
      end else if (x_q[0] == 1'b0) begin
        x_q <= x_q >> 1;
      end else if (y_q[0] == 1'b0) begin
        y_q <= y_q >> 1;
      end else begin
        if (x_q > y_q) x_q <= y_q;
        y_q <= ys;
      end
    end
    if (cmd_i.div_init) begin
      if (!second_q) begin
        x_q <= x_q << sh_q;
        sh_q <= '0;
      end
      dvd_q <= second_q ? den_q : mag_q;
      r_q <= '0;
      q_q <= '0;
      cnt_q <= CntW'(WideW);
    end
    if (cmd_i.div_step) begin
      if (!rsub[WideW-1] || rt >= x_q) begin
        r_q <= (rt >= x_q) ? rsub : rt;
        q_q <= {q_q[WideW-2:0], rt >= x_q};
      end else begin
        r_q <= rt;
        q_q <= {q_q[WideW-2:0], 1'b0};
      end
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.gcd_init) second_q <= 1'b0;
    if (cmd_i.div_step && cnt_q == CntW'(1)) second_q <= ~second_q;
    if (cmd_i.div_step && cnt_q == CntW'(1) && !second_q) begin
      mag_q <= {q_q[WideW-2:0], rt >= x_q};
    end
    if (cmd_i.finish) begin
      equal_out_q <= equal_q;
      error_out_q <= error_q;
      if (special_q) begin
        res_num_q <= '0;
        res_den_q <= (error_q || op_q == CMD_EQ) ? '0 : DenW'(1);
      end else begin
        res_num_q <= neg_q ? NumW'('0 - mag_q) : NumW'(mag_q);
        res_den_q <= DenW'(q_q);
      end
    end
  end

  always_comb begin
    sts_o.special  = special_q;
    sts_o.gcd_done = (y_q == '0);
    sts_o.div_done = (cnt_q == '0);
  end

  // Once y reaches zero the GCD sits in x; the shift is folded back in at
  // the first division setup.
  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign equal_o   = equal_out_q;
  assign error_o   = error_out_q;
endmodule

### rtl/core/rasr_ctrl.sv
// Controller state machine sequencing the datapath and both handshakes.
module rasr_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  rasr_pkg::rasr_sts_t sts_i,
  output rasr_pkg::rasr_cmd_t cmd_o
);
  import rasr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_GCD, S_DINIT, S_DIV, S_FIN, S_OUT
  } state_e;

  state_e state_q;
  logic second_q, ovalid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_MUL:   cmd_o.mul = 1'b1;
      S_COMB:  begin
        cmd_o.comb = 1'b1;
        cmd_o.gcd_init = 1'b1;
      end
      S_GCD:   cmd_o.gcd_step = !sts_i.gcd_done;
      S_DINIT: cmd_o.div_init = 1'b1;
      S_DIV:   cmd_o.div_step = !sts_i.div_done;
      S_FIN:   cmd_o.finish = !ovalid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_MUL;
        S_MUL:   state_q <= S_COMB;
        S_COMB:  state_q <= S_GCD;
        S_GCD: begin
          if (sts_i.special) state_q <= S_FIN;
          else if (sts_i.gcd_done) begin
            state_q  <= S_DINIT;
            second_q <= 1'b0;
          end
        end
        S_DINIT: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_done) begin
            if (second_q) state_q <= S_FIN;
            else begin
              second_q <= 1'b1;
              state_q  <= S_DINIT;
            end
          end
        end
        S_FIN: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/rational_add_sub_reduce.sv
// Top level of the rational add, subtract, negate and equality block.
// Usage: an input word (cmd, a_num, a_den, b_num, b_den) enters on in_ch
// when valid and ready are both high. One result word (res_num, res_den,
// equal, error) leaves on out_ch for every input word, in order.
// The block handles one word at a time. After acceptance it forms the
// cross products, then runs a binary GCD that moves one step per cycle,
// then divides the numerator magnitude and the denominator by the GCD
// with a restoring divider that yields one quotient bit per cycle, 34
// quotient bits for each of the two divisions.
// Zero numerators, errors and equality tests skip the GCD and division;
// otherwise the GCD loop and the one-bit divider take most of the time.
// The result sits in an output register; the next word is accepted once
// the previous word's work is finished, even while the result still waits,
// and only the final write waits when the receiver stalls.
// Reset clears the controller and the output valid flag; there is no
// clearing pass and no configuration.
module rational_add_sub_reduce (
  input logic clk_i,
  input logic rst_ni,
  rasr_in_if.sink in_ch,
  rasr_out_if.source out_ch
);
  import rasr_pkg::*;

  rasr_cmd_t cmd;
  rasr_sts_t sts;

  rasr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rasr_datapath u_dp (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .op_i      (in_ch.cmd),
    .a_num_i   (in_ch.a_num),
    .a_den_i   (in_ch.a_den),
    .b_num_i   (in_ch.b_num),
    .b_den_i   (in_ch.b_den),
    .sts_o     (sts),
    .res_num_o (out_ch.res_num),
    .res_den_o (out_ch.res_den),
    .equal_o   (out_ch.equal),
    .error_o   (out_ch.error)
  );
endmodule

### rtl/core/rasr_checker.sv
// Port-level checker for the rational block and its bind statement.
`include "rational_add_sub_reduce_macros.svh"
module rasr_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [rasr_pkg::NumW-1:0] res_num,
  input logic [rasr_pkg::DenW-1:0] res_den,
  input logic equal,
  input logic error
);
  `RASR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `RASR_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid && error,
    res_num == '0 && res_den == '0 && !equal)
  `RASR_ASSERT_IMP(a_equal_zero, clk_i, rst_ni, out_valid && equal,
    res_num == '0 && res_den == '0 && !error)
  `RASR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
    out_valid && $stable(res_num) && $stable(res_den))
endmodule

bind rational_add_sub_reduce rasr_props u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .res_num   (out_ch.res_num),
  .res_den   (out_ch.res_den),
  .equal     (out_ch.equal),
  .error     (out_ch.error)
);
